// ===== rtl/core/imc_pkg.sv =====
// Shared types, constants and lattice helpers for the checkerboard Ising core.
// Depends on nothing; used by ising_metropolis_checkerboard_core.
`default_nettype none

package imc_pkg;

	// Lattice geometry
	localparam int LATTICE_SIDE = 64;
	localparam int SITE_COUNT   = LATTICE_SIDE * LATTICE_SIDE;
	localparam int SIDE_W       = $clog2(LATTICE_SIDE);
	localparam int SITE_W       = $clog2(SITE_COUNT);
	localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(LATTICE_SIDE - 1);

	// Field widths
	localparam int KIND_W    = 2;
	localparam int INDEX_W   = 12;
	localparam int RAND_W    = 32;
	localparam int MAG_W     = 14;
	localparam int ENE_W     = 15;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 1;
	localparam int S_DATA_W  = ((INDEX_W + 1 + RAND_W + 7) / 8) * 8;
	localparam int M_DATA_W  = ((1 + INDEX_W + MAG_W + ENE_W + 7) / 8) * 8;

	// Agreeing-neighbor counts: dE = 4 * agree - 8
	localparam int AGREE_W = 3;
	localparam logic [AGREE_W-1:0] AGREE_DE4 = AGREE_W'(3);
	localparam logic [AGREE_W-1:0] AGREE_DE8 = AGREE_W'(4);
	localparam int DE_OFFSET = 8;

	// Totals after reset: all spins up
	localparam logic [MAG_W-1:0] MAG_RESET = MAG_W'(SITE_COUNT);
	localparam logic [ENE_W-1:0] ENE_RESET = ENE_W'(-2 * SITE_COUNT);

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD,
		KIND_FILL,
		KIND_RECOUNT,
		KIND_UPDATE
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TH_DE4,
		CFG_TH_DE8
	} cfg_reg_t;

	// Which lattice neighbor a read addresses
	typedef enum logic [2:0] {
		NB_CENTER,
		NB_RIGHT,
		NB_LEFT,
		NB_DOWN,
		NB_UP
	} nbr_t;

	typedef enum logic [2:0] {
		ST_FILL,
		ST_IDLE,
		ST_UPD_RD,
		ST_RC_RD,
		ST_DRAIN,
		ST_UPD_DEC,
		ST_RC_SUM,
		ST_FINISH
	} state_t;

	function automatic logic [SIDE_W-1:0] wrap_inc(input logic [SIDE_W-1:0] v);
		return (v == SIDE_MAX) ? '0 : SIDE_W'(v + 1'b1);
	endfunction

	function automatic logic [SIDE_W-1:0] wrap_dec(input logic [SIDE_W-1:0] v);
		return (v == '0) ? SIDE_MAX : SIDE_W'(v - 1'b1);
	endfunction

	function automatic logic [SITE_W-1:0] site_of(input logic [SIDE_W-1:0] row,
		input logic [SIDE_W-1:0] col);
		return SITE_W'(32'(row) * 32'(LATTICE_SIDE) + 32'(col));
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ising_metropolis_checkerboard_core.sv =====
// Checkerboard Metropolis engine for a periodic 2-D Ising lattice.
// Depends on imc_pkg (geometry, codes, neighbor helpers).
//
// Usage:
//  - Input stream (s_*): s_tuser carries the item kind (load site, fill all,
//    recount totals, update next site); s_tdata carries site_index,
//    spin_up and random_word. One transfer per item, one result per item.
//  - Output stream (m_*): m_tdata carries flipped, site_updated,
//    magnetization_total and energy_total; m_tlast marks the update that
//    closes a sweep (last site of the second color).
//  - cfg_we/cfg_index/cfg_data write the two 0.32 acceptance thresholds
//    (dE = 4 and dE = 8). Write them only while the core is idle.
// Timing: the spin memory has one read and one write port, so every lattice
// read costs one cycle. Cycles from the accepting edge to the result register:
// load 1, update 8 (five reads, one drain, decide/write, result), recount
// 3*N + 3, fill N + 3*N + 3, N = sites. The core takes one item at a time;
// s_tready is high only while idle, which adds one cycle per item, and it
// accepts the next item while the previous result still waits in the output
// register.
// Reset: after arst_n releases, an N-cycle clearing pass sets every spin up
// (s_tready low); totals and sweep position start at their all-up values.
// A stalled receiver holds the result and the core waits before delivering
// the next one.
`default_nettype none

module ising_metropolis_checkerboard_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// site_index[11:0], spin_up[12], random_word[44:13], zero fill above
	input  logic [imc_pkg::S_DATA_W-1:0]  s_tdata,
	// kind[1:0]
	input  logic [imc_pkg::KIND_W-1:0]    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// flipped[0], site_updated[12:1], magnetization_total[26:13],
	// energy_total[41:27], zero fill above
	output logic [imc_pkg::M_DATA_W-1:0]  m_tdata,
	output logic                          m_tlast,
	input  logic                          cfg_we,
	input  logic [imc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [imc_pkg::CFG_W-1:0]     cfg_data
);
	import imc_pkg::*;

	// Sequencer
	state_t state_q, state_d;
	nbr_t   phase_q;
	logic   init_q;
	logic   rc_mode_q;

	// Fill sweep
	logic [SITE_W-1:0] fill_addr_q;
	logic              fill_val_q;

	// Checkerboard position of the next update
	logic              sw_color_q;
	logic [SIDE_W-1:0] sw_row_q, sw_col_q;
	logic              par_next;

	// Recount scan position
	logic [SIDE_W-1:0] rc_row_q, rc_col_q;
	logic              rc_last;

	// Totals and thresholds
	logic [MAG_W-1:0] mag_q;
	logic [ENE_W-1:0] energy_q;
	logic [CFG_W-1:0] th4_q, th8_q;

	// Item payload and accumulators
	logic [RAND_W-1:0]  rnd_q;
	logic               s_q;
	logic [AGREE_W-1:0] agree_q;
	logic [SITE_W:0]    ups_q;
	logic [SITE_W+1:0]  unlike_q;

	// Result staging and output register
	logic               res_flipped_q, res_done_q;
	logic [INDEX_W-1:0] res_site_q;
	logic               m_tvalid_q, m_tlast_q;
	logic [M_DATA_W-1:0] m_tdata_q;
	logic               load_out;

	// Spin memory and read pipeline
	logic              spin_mem [SITE_COUNT];
	logic              mem_we, mem_wdata, issue;
	logic [SITE_W-1:0] mem_waddr, mem_raddr;
	logic              rd_data_s1, rd_vld_s1;
	nbr_t              rd_tag_s1;

	// Input unpacking
	logic [INDEX_W-1:0] site_in;
	logic               spin_in;
	logic [RAND_W-1:0]  rnd_in;
	logic               in_xfer;
	kind_t              kind_in;
	logic               load_ok;

	// Shared decision unit
	logic [SITE_W-1:0]  cur_site;
	logic [CFG_W-1:0]   th_sel;
	logic               rnd_below, flip_ok;
	logic [SIDE_W-1:0]  base_row, base_col, nb_row, nb_col;

	assign site_in  = s_tdata[INDEX_W-1:0];
	assign spin_in  = s_tdata[INDEX_W];
	assign rnd_in   = s_tdata[INDEX_W+1 +: RAND_W];
	assign kind_in  = kind_t'(s_tuser);
	assign in_xfer  = s_tvalid && s_tready;
	assign load_ok  = 32'(site_in) < SITE_COUNT;

	assign cur_site = site_of(sw_row_q, sw_col_q);
	assign par_next = sw_row_q[0] ~^ sw_color_q;
	assign rc_last  = (rc_row_q == SIDE_MAX) && (rc_col_q == SIDE_MAX);

	// One compare serves both thresholds; dE <= 0 always flips
	assign th_sel    = (agree_q == AGREE_DE4) ? th4_q : th8_q;
	assign rnd_below = rnd_q < th_sel;
	assign flip_ok   = (agree_q < AGREE_DE4) || rnd_below;

	assign load_out = (state_q == ST_FINISH) && (!m_tvalid_q || m_tready);

	// Neighbor address for the current read phase
	assign base_row = rc_mode_q ? rc_row_q : sw_row_q;
	assign base_col = rc_mode_q ? rc_col_q : sw_col_q;

	always_comb begin
		nb_row = base_row;
		nb_col = base_col;
		case (phase_q)
			NB_RIGHT: nb_col = wrap_inc(base_col);
			NB_LEFT:  nb_col = wrap_dec(base_col);
			NB_DOWN:  nb_row = wrap_inc(base_row);
			NB_UP:    nb_row = wrap_dec(base_row);
			default: ;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_FILL: begin
				if (fill_addr_q == SITE_W'(SITE_COUNT - 1))
					state_d = init_q ? ST_IDLE : ST_RC_RD;
			end
			ST_IDLE: begin
				if (in_xfer) begin
					unique case (kind_in)
						KIND_LOAD:    state_d = ST_FINISH;
						KIND_FILL:    state_d = ST_FILL;
						KIND_RECOUNT: state_d = ST_RC_RD;
						KIND_UPDATE:  state_d = ST_UPD_RD;
						default:      state_d = ST_FINISH;
					endcase
				end
			end
			ST_UPD_RD: begin
				if (phase_q == NB_UP)
					state_d = ST_DRAIN;
			end
			ST_RC_RD: begin
				if (phase_q == NB_DOWN && rc_last)
					state_d = ST_DRAIN;
			end
			ST_DRAIN:   state_d = rc_mode_q ? ST_RC_SUM : ST_UPD_DEC;
			ST_UPD_DEC: state_d = ST_FINISH;
			ST_RC_SUM:  state_d = ST_FINISH;
			ST_FINISH: begin
				if (!m_tvalid_q || m_tready)
					state_d = ST_IDLE;
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: memory port control and input ready
	always_comb begin
		s_tready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = cur_site;
		mem_wdata = ~s_q;
		issue     = 1'b0;
		mem_raddr = site_of(nb_row, nb_col);
		unique case (state_q) inside
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = fill_addr_q;
				mem_wdata = fill_val_q;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (in_xfer && kind_in == KIND_LOAD && load_ok) begin
					mem_we    = 1'b1;
					mem_waddr = SITE_W'(site_in);
					mem_wdata = spin_in;
				end
			end
			ST_UPD_RD, ST_RC_RD: issue = 1'b1;
			ST_UPD_DEC:          mem_we = flip_ok;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_FILL;
		else
			state_q <= state_d;
	end

	// Spin memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we)
			spin_mem[mem_waddr] <= mem_wdata;
		rd_data_s1 <= spin_mem[mem_raddr];
		rd_tag_s1  <= phase_q;
	end

	// Control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= NB_CENTER;
			init_q      <= 1'b1;
			rc_mode_q   <= 1'b0;
			fill_addr_q <= '0;
			fill_val_q  <= 1'b1;
			sw_color_q  <= 1'b0;
			sw_row_q    <= '0;
			sw_col_q    <= '0;
			rc_row_q    <= '0;
			rc_col_q    <= '0;
			mag_q       <= MAG_RESET;
			energy_q    <= ENE_RESET;
			th4_q       <= '0;
			th8_q       <= '0;
			m_tvalid_q  <= 1'b0;
			rd_vld_s1   <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;

			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_TH_DE4: th4_q <= cfg_data;
					CFG_TH_DE8: th8_q <= cfg_data;
					default: ;
				endcase
			end

			// Start of an item: pick the scan mode and rewind the phase
			if (in_xfer) begin
				phase_q   <= NB_CENTER;
				rc_mode_q <= (kind_in == KIND_FILL) || (kind_in == KIND_RECOUNT);
				rc_row_q  <= '0;
				rc_col_q  <= '0;
				if (kind_in == KIND_FILL) begin
					fill_addr_q <= '0;
					fill_val_q  <= spin_in;
				end
			end

			if (state_q == ST_FILL) begin
				fill_addr_q <= SITE_W'(fill_addr_q + 1'b1);
				if (fill_addr_q == SITE_W'(SITE_COUNT - 1))
					init_q <= 1'b0;
			end

			// Advance the read phase: five reads per update
			if (state_q == ST_UPD_RD) begin
				case (phase_q)
					NB_CENTER: phase_q <= NB_RIGHT;
					NB_RIGHT:  phase_q <= NB_LEFT;
					NB_LEFT:   phase_q <= NB_DOWN;
					NB_DOWN:   phase_q <= NB_UP;
					default:   phase_q <= NB_CENTER;
				endcase
			end

			// Three reads per site during a recount, then step the scan
			if (state_q == ST_RC_RD) begin
				case (phase_q)
					NB_CENTER: phase_q <= NB_RIGHT;
					NB_RIGHT:  phase_q <= NB_DOWN;
					default: begin
						phase_q  <= NB_CENTER;
						rc_col_q <= wrap_inc(rc_col_q);
						if (rc_col_q == SIDE_MAX)
							rc_row_q <= wrap_inc(rc_row_q);
					end
				endcase
			end

			if (state_q == ST_UPD_DEC) begin
				if (flip_ok) begin
					mag_q    <= s_q ? MAG_W'(mag_q - MAG_W'(2)) : MAG_W'(mag_q + MAG_W'(2));
					energy_q <= ENE_W'(energy_q + ENE_W'({agree_q, 2'b00})
						- ENE_W'(DE_OFFSET));
				end
				// Step to the next site of the same color, then the other color
				if (32'(sw_col_q) + 2 < LATTICE_SIDE) begin
					sw_col_q <= SIDE_W'(sw_col_q + SIDE_W'(2));
				end else if (sw_row_q != SIDE_MAX) begin
					sw_row_q <= SIDE_W'(sw_row_q + 1'b1);
					sw_col_q <= SIDE_W'(par_next);
				end else if (!sw_color_q) begin
					sw_color_q <= 1'b1;
					sw_row_q   <= '0;
					sw_col_q   <= SIDE_W'(1);
				end else begin
					sw_color_q <= 1'b0;
					sw_row_q   <= '0;
					sw_col_q   <= '0;
				end
			end

			if (state_q == ST_RC_SUM) begin
				mag_q    <= MAG_W'(32'(ups_q) * 2 - SITE_COUNT);
				energy_q <= ENE_W'(32'(unlike_q) * 2 - 2 * SITE_COUNT);
			end

			if (load_out)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// Payload, accumulators and result staging
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			rnd_q         <= rnd_in;
			agree_q       <= '0;
			ups_q         <= '0;
			unlike_q      <= '0;
			res_flipped_q <= 1'b0;
			res_done_q    <= 1'b0;
			res_site_q    <= '0;
		end

		// Consume the spin read in the cycle after its address went out
		if (rd_vld_s1) begin
			if (rd_tag_s1 == NB_CENTER) begin
				s_q <= rd_data_s1;
				if (rc_mode_q)
					ups_q <= ups_q + (SITE_W + 1)'(rd_data_s1);
			end else if (rc_mode_q) begin
				unlike_q <= unlike_q + (SITE_W + 2)'(rd_data_s1 != s_q);
			end else begin
				agree_q <= agree_q + AGREE_W'(rd_data_s1 == s_q);
			end
		end

		if (state_q == ST_UPD_DEC) begin
			res_flipped_q <= flip_ok;
			res_site_q    <= INDEX_W'(cur_site);
			res_done_q    <= sw_color_q && (sw_row_q == SIDE_MAX)
				&& !(32'(sw_col_q) + 2 < LATTICE_SIDE);
		end

		if (load_out) begin
			m_tdata_q <= M_DATA_W'({energy_q, mag_q, res_site_q, res_flipped_q});
			m_tlast_q <= res_done_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// Checks

	// One item at a time: the core drops ready right after a transfer
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while an item is in progress");

	// The sweep position always sits on a site of its own color
	a_sweep_color: assert property (@(posedge clk) disable iff (!arst_n)
		((sw_row_q[0] ^ sw_col_q[0]) == sw_color_q))
		else $error("sweep position left its checkerboard color");

	// A flip writes the inverted spin back to the visited site only
	a_flip_target: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD_DEC && mem_we) |-> (mem_waddr == cur_site && mem_wdata == !s_q))
		else $error("flip wrote the wrong site or value");

	// At most four neighbors can agree with the center spin
	a_agree_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD_DEC) |-> (agree_q <= AGREE_DE8))
		else $error("agreeing-neighbor count out of range");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for ising_metropolis_checkerboard_core: drives the item stream,
// predicts each result from an in-bench lattice model and compares every field.
// Depends on imc_pkg and the core RTL only.

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import imc_pkg::*;

	localparam int SCAN_LEN     = 2 * SITE_COUNT;
	localparam int SITE_LSB     = 1;
	localparam int MAG_LSB      = SITE_LSB + INDEX_W;
	localparam int ENE_LSB      = MAG_LSB + MAG_W;
	localparam int FILL_LSB     = ENE_LSB + ENE_W;
	localparam int RESET_CYCLES = 8;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int LIMIT_CYCLES = 3_000_000;
	localparam int MAX_REPORTS  = 10;
	localparam logic [RAND_W-1:0] WORD_MAX = '1;

	// One expected or observed result transfer
	typedef struct packed {
		logic               flipped;
		logic [INDEX_W-1:0] site;
		logic [MAG_W-1:0]   mag;
		logic [ENE_W-1:0]   ene;
		logic               done;
	} sweep_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [KIND_W-1:0] s_tuser = KIND_LOAD;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic m_tlast;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_TH_DE4;
	logic [CFG_W-1:0] cfg_data = '0;

	ising_metropolis_checkerboard_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		// site_index[11:0], spin_up[12], random_word[44:13], zero fill above
		.s_tdata  (s_tdata),
		// kind[1:0]
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		// flipped[0], site_updated[12:1], magnetization_total[26:13],
		// energy_total[41:27], zero fill above
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Lattice model: spins, running totals, scan position, thresholds
	// ------------------------------------------------------------------
	bit spin_grid [SITE_COUNT];
	int mag_sum;
	int ene_sum;
	int scan_pos;
	logic [CFG_W-1:0] th_de4;
	logic [CFG_W-1:0] th_de8;

	sweep_result_t pending_results[$];
	int mismatch_count = 0;
	int cycle_count = 0;

	// Sender burst state and receiver hold request (set by tests, served by receiver)
	bit sender_idle_on = 1'b1;
	int burst_left = 0;
	int hold_requests = 0;
	int hold_served = 0;

	function automatic int wrap_next(int v);
		return (v + 1 >= LATTICE_SIDE) ? 0 : v + 1;
	endfunction

	function automatic int wrap_prev(int v);
		return (v == 0) ? LATTICE_SIDE - 1 : v - 1;
	endfunction

	function automatic int spin_at(int x, int y);
		return spin_grid[y * LATTICE_SIDE + x] ? 1 : -1;
	endfunction

	function automatic void recount_totals();
		int m;
		int e;
		m = 0;
		e = 0;
		for (int y = 0; y < LATTICE_SIDE; y++) begin
			for (int x = 0; x < LATTICE_SIDE; x++) begin
				m += spin_at(x, y);
				e -= spin_at(x, y) * (spin_at(wrap_next(x), y) + spin_at(x, wrap_next(y)));
			end
		end
		mag_sum = m;
		ene_sum = e;
	endfunction

	// Color zero covers (x + y) even, color one the odd sites
	function automatic bit color_matches(int pos);
		int site;
		site = pos % SITE_COUNT;
		return (((site % LATTICE_SIDE) + (site / LATTICE_SIDE)) & 1) == (pos / SITE_COUNT);
	endfunction

	function automatic int next_scan(int pos);
		int p;
		p = pos;
		while (p < SCAN_LEN && !color_matches(p))
			p++;
		return p;
	endfunction

	function automatic int upcoming_site();
		int p;
		p = next_scan(scan_pos);
		if (p >= SCAN_LEN)
			p = next_scan(0);
		return p % SITE_COUNT;
	endfunction

	// Append a prediction behind the ones still waiting
	function automatic void queue_prediction(sweep_result_t r);
		pending_results.insert(pending_results.size(), r);
	endfunction

	function automatic sweep_result_t lattice_step(kind_t kind, logic [INDEX_W-1:0] idx,
		logic spin, logic [RAND_W-1:0] rnd);
		sweep_result_t res;
		int p;
		int site;
		int x;
		int y;
		int s;
		int nn;
		int de;
		bit accept;
		res = '0;
		case (kind)
			KIND_LOAD: begin
				if (int'(idx) < SITE_COUNT)
					spin_grid[idx] = spin;
			end
			KIND_FILL: begin
				foreach (spin_grid[i])
					spin_grid[i] = spin;
				recount_totals();
			end
			KIND_RECOUNT: begin
				recount_totals();
			end
			default: begin
				p = next_scan(scan_pos);
				if (p >= SCAN_LEN)
					p = next_scan(0);
				site = p % SITE_COUNT;
				x = site % LATTICE_SIDE;
				y = site / LATTICE_SIDE;
				s = spin_at(x, y);
				nn = spin_at(wrap_next(x), y) + spin_at(wrap_prev(x), y)
					+ spin_at(x, wrap_next(y)) + spin_at(x, wrap_prev(y));
				de = 2 * s * nn;
				if (de <= 0)
					accept = 1'b1;
				else if (de == 4)
					accept = rnd < th_de4;
				else if (de == 8)
					accept = rnd < th_de8;
				else
					accept = 1'b0;
				if (accept) begin
					spin_grid[site] = !spin_grid[site];
					mag_sum -= 2 * s;
					ene_sum += de;
					res.flipped = 1'b1;
				end
				res.site = INDEX_W'(site);
				p = next_scan(p + 1);
				if (p >= SCAN_LEN) begin
					res.done = 1'b1;
					p = 0;
				end
				scan_pos = p;
			end
		endcase
		res.mag = MAG_W'(mag_sum);
		res.ene = ENE_W'(ene_sum);
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Offer one item and hold it until the transfer; valid stays high on return
	// so that a following item goes out back to back.
	task automatic send_item(input kind_t kind, input logic [INDEX_W-1:0] idx,
		input logic spin, input logic [RAND_W-1:0] rnd);
		int gap;
		if (sender_idle_on) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 8);
				burst_left = $urandom_range(1, 16);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left--;
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {{(S_DATA_W - INDEX_W - 1 - RAND_W){1'b0}}, rnd, spin, idx};
		do
			@(posedge clk);
		while (!s_tready);
		queue_prediction(lattice_step(kind, idx, spin, rnd));
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Write both thresholds while the core sits idle
	task automatic set_thresholds(input logic [CFG_W-1:0] de4, input logic [CFG_W-1:0] de8);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= CFG_TH_DE4;
		cfg_data <= de4;
		@(posedge clk);
		th_de4 = de4;
		cfg_index <= CFG_TH_DE8;
		cfg_data <= de8;
		@(posedge clk);
		th_de8 = de8;
		cfg_we <= 1'b0;
	endtask

	task automatic send_random_item();
		int pick;
		int site;
		int x;
		int y;
		kind_t kind;
		logic [INDEX_W-1:0] idx;
		logic [RAND_W-1:0] rnd;
		pick = $urandom_range(99);
		if (pick < 45)
			kind = KIND_UPDATE;
		else if (pick < 89)
			kind = KIND_LOAD;
		else if (pick < 95)
			kind = KIND_RECOUNT;
		else if (pick < 96)
			kind = KIND_FILL;
		else
			kind = KIND_UPDATE;
		idx = INDEX_W'($urandom);
		// Most loads land on or next to the site the scan visits next, so the
		// updates see mixed neighborhoods instead of a uniform lattice.
		if (kind == KIND_LOAD && $urandom_range(3) != 0) begin
			site = upcoming_site();
			x = site % LATTICE_SIDE;
			y = site / LATTICE_SIDE;
			case ($urandom_range(4))
				0: x = wrap_next(x);
				1: x = wrap_prev(x);
				2: y = wrap_next(y);
				3: y = wrap_prev(y);
				default: ;
			endcase
			idx = INDEX_W'(y * LATTICE_SIDE + x);
		end
		// Aim the random word at the threshold edges now and then
		case ($urandom_range(7))
			0: rnd = th_de4 - 1'b1;
			1: rnd = th_de4;
			2: rnd = th_de8 - 1'b1;
			3: rnd = th_de8;
			default: rnd = $urandom;
		endcase
		send_item(kind, idx, 1'($urandom), rnd);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Totals after the clearing pass; zero thresholds reject a dE of eight
	task automatic test_reset_totals();
		send_item(KIND_RECOUNT, '1, 1'b0, WORD_MAX);
		send_item(KIND_UPDATE, '0, 1'b0, '0);
		send_item(KIND_UPDATE, '1, 1'b1, '0);
	endtask

	// Strict compare: an all-ones word fails even an all-ones threshold
	task automatic test_strict_threshold();
		set_thresholds(WORD_MAX, WORD_MAX);
		send_item(KIND_UPDATE, '0, 1'b0, WORD_MAX);
		send_item(KIND_UPDATE, '0, 1'b0, WORD_MAX - 1'b1);
		send_item(KIND_UPDATE, '0, 1'b1, '0);
	endtask

	// Loads leave the totals stale until a recount; fills recount on their own
	task automatic test_load_and_fill();
		send_item(KIND_LOAD, '0, 1'b0, '0);
		send_item(KIND_LOAD, '1, 1'b0, WORD_MAX);
		send_item(KIND_UPDATE, '0, 1'b0, '0);
		send_item(KIND_RECOUNT, '0, 1'b0, '0);
		send_item(KIND_LOAD, '1, 1'b1, '0);
		send_item(KIND_FILL, '0, 1'b0, '0);
		send_item(KIND_UPDATE, '0, 1'b0, '0);
		send_item(KIND_RECOUNT, '0, 1'b1, '0);
		send_item(KIND_FILL, '1, 1'b1, WORD_MAX);
		send_item(KIND_UPDATE, '0, 1'b0, WORD_MAX);
		send_item(KIND_RECOUNT, '0, 1'b0, '0);
	endtask

	// Hold the receiver off while items keep coming, so the core backs up
	task automatic test_backpressure();
		drain_results();
		sender_idle_on = 1'b0;
		hold_requests++;
		for (int i = 0; i < 12; i++)
			send_item(i % 4 == 0 ? KIND_LOAD : KIND_UPDATE, INDEX_W'($urandom), 1'($urandom),
				$urandom);
		sender_idle_on = 1'b1;
	endtask

	task automatic test_random_mix();
		logic [CFG_W-1:0] de4_set [4];
		logic [CFG_W-1:0] de8_set [4];
		de4_set = '{'0, WORD_MAX, $urandom, 32'h6000_0000};
		de8_set = '{'0, WORD_MAX, $urandom, 32'h2400_0000};
		for (int ph = 0; ph < 4; ph++) begin
			set_thresholds(de4_set[ph], de8_set[ph]);
			for (int i = 0; i < 70; i++) begin
				// Run part of each phase without sender gaps
				sender_idle_on = (i >= 40);
				send_random_item();
			end
		end
		sender_idle_on = 1'b1;
	endtask

	// A long run of updates along the checkerboard scan at mid-range thresholds
	task automatic test_update_run();
		set_thresholds(32'h6000_0000, 32'h2400_0000);
		for (int i = 0; i < 100; i++)
			send_item(KIND_UPDATE, INDEX_W'($urandom), 1'($urandom), $urandom);
	endtask

	// ------------------------------------------------------------------
	// Receiver: changing stall patterns, plus a long hold on request
	// ------------------------------------------------------------------
	int hold_left = 0;
	int mode_left = 0;
	int recv_mode = 0;

	always @(posedge clk) begin
		if (hold_served != hold_requests) begin
			hold_left = HOLD_CYCLES;
			hold_served++;
		end
		if (mode_left == 0) begin
			recv_mode = $urandom_range(3);
			mode_left = $urandom_range(32, 256);
		end
		mode_left--;
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (recv_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(3) != 0);
				2: m_tready <= 1'($urandom_range(1));
				default: m_tready <= (mode_left % 4 != 0);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Checker: compare each result transfer with the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		sweep_result_t seen;
		sweep_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			seen.flipped = m_tdata[0];
			seen.site = m_tdata[SITE_LSB +: INDEX_W];
			seen.mag = m_tdata[MAG_LSB +: MAG_W];
			seen.ene = m_tdata[ENE_LSB +: ENE_W];
			seen.done = m_tlast;
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("[%0t] unexpected result: flipped %0b site %0d mag %0d ene %0d last %0b",
						$realtime, seen.flipped, seen.site, $signed(seen.mag),
						$signed(seen.ene), seen.done);
			end else begin
				want = pending_results.pop_front();
				if (seen !== want || m_tdata[M_DATA_W-1:FILL_LSB] !== '0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$write("[%0t] mismatch (expected/actual): flipped %0b/%0b site %0d/%0d",
							$realtime, want.flipped, seen.flipped, want.site, seen.site);
						$display(" mag %0d/%0d ene %0d/%0d last %0b/%0b fill %0h",
							$signed(want.mag), $signed(seen.mag), $signed(want.ene),
							$signed(seen.ene), want.done, seen.done,
							m_tdata[M_DATA_W-1:FILL_LSB]);
					end
				end
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("** ising_metropolis_checkerboard_core: FAILED **");
			$finish;
		end
	end

	initial begin
		// Model state after reset: every spin up, totals at their all-up values
		foreach (spin_grid[i])
			spin_grid[i] = 1'b1;
		mag_sum = SITE_COUNT;
		ene_sum = -2 * SITE_COUNT;
		scan_pos = 0;
		th_de4 = '0;
		th_de8 = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_totals();
		test_strict_threshold();
		test_load_and_fill();
		test_backpressure();
		test_random_mix();
		test_update_run();

		// Let the last results come out, then wait out the drain period
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			mismatch_count++;
		if (mismatch_count == 0) begin
			$display("** ising_metropolis_checkerboard_core: PASSED **");
		end else begin
			$display("** ising_metropolis_checkerboard_core: FAILED **");
		end
		$finish;
	end

endmodule
